FILE: rtl/hsm_pkg.sv
package hsm_pkg;

  // Configuration register index
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHADOW_ENABLE = 2'd0,
    REG_ELEV_MIN      = 2'd1,
    REG_ELEV_MAX      = 2'd2
  } cfg_reg_t;

  // Number of cell hit bits folded by one first-level OR
  localparam int OR_GROUP = 8;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic shift;      // new sample enters the chain this cycle
    logic row_start;  // the sample opens a new row
  } cell_ctrl_t;

endpackage

FILE: rtl/hsm_in_if.sv
interface hsm_in_if #(
  parameter int HEIGHT_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height;
  logic                          row_start;

  modport source (output valid, output height, output row_start, input ready);
  modport sink   (input valid, input height, input row_start, output ready);
endinterface

FILE: rtl/hsm_out_if.sv
interface hsm_out_if;
  logic valid;
  logic ready;
  logic shadowed;

  modport source (output valid, output shadowed, input ready);
  modport sink   (input valid, input shadowed, output ready);
endinterface

FILE: rtl/hsm_cfg_if.sv
interface hsm_cfg_if #(
  parameter int HEIGHT_BITS = 16
);
  logic                    valid;
  logic                    ready;
  hsm_pkg::cfg_idx_t       index;
  logic [HEIGHT_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/hsm_cell.sv
module hsm_cell #(
  parameter int HEIGHT_BITS = 16,
  parameter int STEP        = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hsm_pkg::cell_ctrl_t           ctrl,
  input  logic signed [HEIGHT_BITS-1:0] query_h,
  input  logic signed [HEIGHT_BITS-1:0] prev_h,
  input  logic                          prev_valid,
  output logic signed [HEIGHT_BITS-1:0] h_r,
  output logic                          valid_r,
  output logic                          hit_r
);
  import hsm_pkg::*;

  localparam int CW = HEIGHT_BITS + 12;

  logic signed [CW-1:0] diff;
  logic signed [CW-1:0] diff5;
  logic signed [CW-1:0] lim;
  logic                 valid_nxt;
  logic                 hit_nxt;

  // Test 5*(stored - query) >= 4*STEP against the cell's own distance
  always_comb begin
    diff      = CW'(h_r) - CW'(query_h);
    diff5     = (diff <<< 2) + diff;
    lim       = CW'(4 * STEP);
    hit_nxt   = valid_r && !ctrl.row_start && (diff5 >= lim);
    // first cell always takes the new sample; the rest drop out on a row start
    valid_nxt = prev_valid && ((STEP == 1) || !ctrl.row_start);
  end

  // Advance the history one place and hold the hit for the OR tree
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      h_r <= prev_h;
    end
  end

endmodule

FILE: rtl/hsm_or_stage.sv
module hsm_or_stage #(
  parameter int IN_W  = 96,
  parameter int GROUP = 8
) (
  input  logic                                clk,
  input  logic                                load,
  input  logic [IN_W-1:0]                     in_bits,
  output logic [(IN_W + GROUP - 1)/GROUP-1:0] out_r
);
  localparam int NG = (IN_W + GROUP - 1) / GROUP;

  logic [NG*GROUP-1:0] padded;
  logic [NG-1:0]       out_nxt;

  // Zero-fill the last group
  always_comb begin
    padded            = '0;
    padded[IN_W-1:0]  = in_bits;
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    assign out_nxt[g] = |padded[g*GROUP +: GROUP];
  end

  // Register one OR per group
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

endmodule

FILE: rtl/heightfield_shadow_mask.sv
// Streaming shadow mask for a terrain height grid. Height samples enter in
// row-major order, one per transfer, with row_start marking the first cell of
// each row; each sample is clamped to [elev_min, elev_max] (raised first, then
// lowered, so an inverted range gives elev_max). A result is shadowed when one
// of the last MARCH_STEPS cells of the same row satisfies
// 5*(h[j-s] - h[j]) >= 4*s. The block takes one sample per clock and keeps
// taking them as long as the result side drains. The clamp register loads at
// the sample's transfer; the result is then registered in the compare cells,
// the group OR and the output register, in that order, before it is offered.
// The history is a chain of MARCH_STEPS cells, one per distance, all tested in the same cycle.
// Configuration writes are always taken and must only be issued while the
// block is idle; shadow_enable = 0 forces every result to 0 while the history
// still updates.
module heightfield_shadow_mask #(
  parameter int MARCH_STEPS = 96,
  parameter int HEIGHT_BITS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  hsm_in_if.sink    in_ch,
  hsm_out_if.source out_ch,
  hsm_cfg_if.sink   cfg_ch
);
  import hsm_pkg::*;

  localparam int NG = (MARCH_STEPS + OR_GROUP - 1) / OR_GROUP;

  typedef logic signed [HEIGHT_BITS-1:0] height_t;

  // Configuration registers
  logic    shadow_enable_r;
  height_t elev_min_r;
  height_t elev_max_r;

  // Pipeline valids and payload
  logic    valid1_r, valid2_r, valid3_r, out_valid_r;
  height_t h1_r;
  logic    rs1_r;
  logic    shadowed_r;

  logic    mv12, mv23, mv34, in_acc;
  height_t clamp_lo, clamp_h;

  height_t          hist_h [MARCH_STEPS];
  logic [MARCH_STEPS-1:0] hist_v;
  logic [MARCH_STEPS-1:0] hits;
  logic [NG-1:0]          grp_r;
  cell_ctrl_t             ctrl;

  // Stage handshakes: a stage moves when the next is empty or moving
  always_comb begin
    mv34   = valid3_r && (!out_valid_r || out_ch.ready);
    mv23   = valid2_r && (!valid3_r || mv34);
    mv12   = valid1_r && (!valid2_r || mv23);
    in_acc = in_ch.valid && in_ch.ready;
  end

  assign in_ch.ready   = !valid1_r || mv12;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.shadowed = shadowed_r;

  // Clamp: raise to the minimum, then lower to the maximum
  always_comb begin
    clamp_lo = (in_ch.height < elev_min_r) ? elev_min_r : in_ch.height;
    clamp_h  = (clamp_lo > elev_max_r) ? elev_max_r : clamp_lo;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_enable_r <= 1'b1;
      elev_min_r      <= {1'b1, {(HEIGHT_BITS-1){1'b0}}};
      elev_max_r      <= {1'b0, {(HEIGHT_BITS-1){1'b1}}};
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SHADOW_ENABLE: shadow_enable_r <= cfg_ch.data[0];
        REG_ELEV_MIN:      elev_min_r      <= cfg_ch.data;
        REG_ELEV_MAX:      elev_max_r      <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r    <= 1'b0;
      valid2_r    <= 1'b0;
      valid3_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid1_r    <= in_acc || (valid1_r && !mv12);
      valid2_r    <= mv12 || (valid2_r && !mv23);
      valid3_r    <= mv23 || (valid3_r && !mv34);
      out_valid_r <= mv34 || (out_valid_r && !out_ch.ready);
    end
  end

  // Hold the clamped sample until it enters the cell chain
  always_ff @(posedge clk) begin
    if (in_acc) begin
      h1_r  <= clamp_h;
      rs1_r <= in_ch.row_start;
    end
  end

  assign ctrl.shift     = mv12;
  assign ctrl.row_start = rs1_r;

  // Cell chain: cell k holds the sample k+1 places back
  for (genvar k = 0; k < MARCH_STEPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      hsm_cell #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .STEP        (1)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .query_h    (h1_r),
        .prev_h     (h1_r),
        .prev_valid (1'b1),
        .h_r        (hist_h[k]),
        .valid_r    (hist_v[k]),
        .hit_r      (hits[k])
      );
    end else begin : g_body
      hsm_cell #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .STEP        (k + 1)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .query_h    (h1_r),
        .prev_h     (hist_h[k-1]),
        .prev_valid (hist_v[k-1]),
        .h_r        (hist_h[k]),
        .valid_r    (hist_v[k]),
        .hit_r      (hits[k])
      );
    end
  end

  // First OR level over groups of cells
  hsm_or_stage #(
    .IN_W  (MARCH_STEPS),
    .GROUP (OR_GROUP)
  ) u_or (
    .clk     (clk),
    .load    (mv23),
    .in_bits (hits),
    .out_r   (grp_r)
  );

  // Final OR and enable into the output register
  always_ff @(posedge clk) begin
    if (mv34) begin
      shadowed_r <= shadow_enable_r && (|grp_r);
    end
  end

endmodule

FILE: test/heightfield_shadow_mask_tb.sv
module heightfield_shadow_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsm_pkg::*;

  localparam int MARCH_STEPS    = 96;
  localparam int HEIGHT_BITS    = 16;
  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  // How the expected bit of a directed row is obtained
  typedef enum logic [1:0] {
    EXP_CLEAR,
    EXP_SHADOW,
    EXP_MODEL
  } exp_kind_t;

  // Terrain shapes for the random rows
  typedef enum logic [1:0] {
    ROW_WALK,
    ROW_NOISE,
    ROW_PROBE
  } row_shape_t;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] height;
    logic                          row_start;
    exp_kind_t                     kind;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  // Directed cells, run right after reset with the reset register values
  dir_row_t dir_tbl [DIR_ROWS] = '{
    // samples before any row mark, on an empty history
    '{16'sd0,      1'b0, EXP_CLEAR},
    '{16'sd0,      1'b0, EXP_CLEAR},
    '{-16'sd1,     1'b0, EXP_SHADOW},
    // full-range extremes
    '{16'sh7fff,   1'b1, EXP_CLEAR},
    '{16'sh8000,   1'b0, EXP_SHADOW},
    '{16'sh7fff,   1'b0, EXP_CLEAR},
    // row mark empties a history that would shadow
    '{16'sh8000,   1'b1, EXP_CLEAR},
    '{16'sh8000,   1'b0, EXP_CLEAR},
    // exact boundary five cells back
    '{16'sd4,      1'b1, EXP_CLEAR},
    '{-16'sd100,   1'b0, EXP_SHADOW},
    '{-16'sd100,   1'b0, EXP_MODEL},
    '{-16'sd100,   1'b0, EXP_MODEL},
    '{-16'sd100,   1'b0, EXP_MODEL},
    '{16'sd0,      1'b0, EXP_MODEL},
    // one unit short of the boundary
    '{16'sd4,      1'b1, EXP_CLEAR},
    '{-16'sd100,   1'b0, EXP_MODEL},
    '{-16'sd100,   1'b0, EXP_MODEL},
    '{-16'sd100,   1'b0, EXP_MODEL},
    '{-16'sd100,   1'b0, EXP_MODEL},
    '{16'sd1,      1'b0, EXP_MODEL},
    // back-to-back row marks
    '{16'sh7fff,   1'b1, EXP_CLEAR},
    '{16'sh8000,   1'b1, EXP_CLEAR},
    '{16'sh8000,   1'b0, EXP_MODEL}
  };

  logic clk = 1'b0;
  logic rst_n;

  hsm_in_if  #(.HEIGHT_BITS(HEIGHT_BITS)) in_ch ();
  hsm_out_if                              out_ch ();
  hsm_cfg_if #(.HEIGHT_BITS(HEIGHT_BITS)) cfg_ch ();

  heightfield_shadow_mask #(
    .MARCH_STEPS (MARCH_STEPS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: register copies and clamped row history, newest first
  logic                          shadow_on = 1'b1;
  logic signed [HEIGHT_BITS-1:0] elev_lo   = 16'sh8000;
  logic signed [HEIGHT_BITS-1:0] elev_hi   = 16'sh7fff;
  logic signed [HEIGHT_BITS-1:0] hist [MARCH_STEPS];
  int                            hist_fill = 0;

  bit        pending_shadow_q [$];
  exp_kind_t cell_kind = EXP_MODEL;
  bit        pred_bit;
  bit        due_bit;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int err_cnt      = 0;
  int cells_sent   = 0;
  int results_seen = 0;
  int shadow_seen  = 0;
  int cfg_writes   = 0;
  int rows_sent    = 0;
  int long_rows    = 0;
  int idle_cycles  = 0;

  // Clamp the sample, march back along the row, then push it into the history
  function automatic bit predict_shadow(input logic signed [HEIGHT_BITS-1:0] raw,
                                        input logic rs);
    logic signed [HEIGHT_BITS-1:0] h;
    int s;
    bit hit;
    h = raw;
    if (h < elev_lo) h = elev_lo;
    if (h > elev_hi) h = elev_hi;
    if (rs) hist_fill = 0;
    hit = 1'b0;
    for (s = 1; s <= hist_fill; s++)
      if (5 * (int'(hist[s-1]) - int'(h)) >= 4 * s) hit = 1'b1;
    for (s = MARCH_STEPS - 1; s > 0; s--) hist[s] = hist[s-1];
    hist[0] = h;
    if (hist_fill < MARCH_STEPS) hist_fill++;
    return shadow_on && hit;
  endfunction

  // Receiver side: stall at the phase's rate
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Track register writes, predict on every input transfer, check every result
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cfg_writes++;
        case (cfg_ch.index)
          REG_SHADOW_ENABLE: shadow_on = cfg_ch.data[0];
          REG_ELEV_MIN:      elev_lo   = cfg_ch.data;
          REG_ELEV_MAX:      elev_hi   = cfg_ch.data;
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        cells_sent++;
        pred_bit = predict_shadow(in_ch.height, in_ch.row_start);
        case (cell_kind)
          EXP_CLEAR:  pending_shadow_q.push_back(1'b0);
          EXP_SHADOW: pending_shadow_q.push_back(1'b1);
          default:    pending_shadow_q.push_back(pred_bit);
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.shadowed === 1'b1) shadow_seen++;
        if (pending_shadow_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("result %0d arrived with nothing expected (shadowed=%0b)",
                     results_seen, out_ch.shadowed);
          err_cnt++;
        end else begin
          due_bit = pending_shadow_q.pop_front();
          if (out_ch.shadowed !== due_bit) begin
            if (err_cnt < MAX_REPORTS)
              $display("result %0d mismatch: expected shadowed=%0b, got %0b",
                       results_seen, due_bit, out_ch.shadowed);
            err_cnt++;
          end
        end
      end

      // Watchdog: count cycles without any transfer
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("no transfer for %0d cycles, %0d results still due",
                   idle_cycles, pending_shadow_q.size());
          $display("heightfield_shadow_mask_tb NOT OK");
          $finish;
        end
      end
    end
  end

  // Offer one cell, idling first at the phase's rate; return on its transfer
  task automatic push_cell(input logic signed [HEIGHT_BITS-1:0] h, input logic rs,
                           input exp_kind_t kind);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.height    <= h;
    in_ch.row_start <= rs;
    cell_kind       <= kind;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold the sender until every due result has come, then let the pipe settle
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_shadow_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [HEIGHT_BITS-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Generate one row of terrain; an unmarked row continues the previous one
  task automatic send_row(input logic marked, output int len);
    row_shape_t shape;
    int pick, base, cur, i, dmin;
    logic [31:0] rnd;
    logic signed [HEIGHT_BITS-1:0] h;
    pick = $urandom_range(0, 9);
    shape = (pick < 5) ? ROW_WALK : (pick < 7) ? ROW_NOISE : ROW_PROBE;
    if (shape == ROW_PROBE)
      len = $urandom_range(0, 1) ? $urandom_range(94, 99) : $urandom_range(2, 40);
    else
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(97, 130) : $urandom_range(1, 24);
    base = int'($urandom_range(0, 40000)) - 20000;
    if (shape == ROW_WALK && $urandom_range(0, 7) == 0)
      base = $urandom_range(0, 1) ? 32767 : -32768;
    cur = base;
    rows_sent++;
    if (len > MARCH_STEPS) long_rows++;
    for (i = 0; i < len; i++) begin
      case (shape)
        ROW_WALK: begin
          if (i > 0) cur += int'($urandom_range(0, 4)) - 2;
          if (cur > 32767) cur = 32767;
          if (cur < -32768) cur = -32768;
          h = cur[15:0];
          // drop in an occasional extreme spike
          if ($urandom_range(0, 15) == 0) h = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end
        ROW_NOISE: begin
          rnd = $urandom();
          h = rnd[15:0];
        end
        default: begin
          // peak, deep trough, then a probe right at the slope limit
          if (i == 0) begin
            cur = base;
          end else if (i == len - 1) begin
            dmin = (4 * i + 4) / 5;
            cur = base - (dmin - 1 + int'($urandom_range(0, 1)));
          end else begin
            cur = base - 3000;
          end
          h = cur[15:0];
        end
      endcase
      push_cell(h, marked && (i == 0), EXP_MODEL);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_cells);
    int sent, len;
    logic marked;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent   = 0;
    marked = 1'b0;
    while (sent < n_cells) begin
      send_row(marked, len);
      sent += len;
      // mostly marked rows, some merged into the previous row
      marked = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 29) == 0) drain_results();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.height    = '0;
    in_ch.row_start = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_SHADOW_ENABLE;
    cfg_ch.data     = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed cells on the reset configuration
    foreach (dir_tbl[i]) push_cell(dir_tbl[i].height, dir_tbl[i].row_start, dir_tbl[i].kind);

    // Full range, no idling
    drain_results();
    write_reg(REG_SHADOW_ENABLE, 16'd1);
    write_reg(REG_ELEV_MIN, 16'sh8000);
    write_reg(REG_ELEV_MAX, 16'sh7fff);
    run_phase(0, 0, 100);

    // Narrow clamp, sender idling
    drain_results();
    write_reg(REG_ELEV_MIN, -16'sd100);
    write_reg(REG_ELEV_MAX, 16'sd100);
    run_phase(64, 0, 90);

    // Inverted clamp range, receiver stalling
    drain_results();
    write_reg(REG_ELEV_MIN, 16'sd50);
    write_reg(REG_ELEV_MAX, -16'sd50);
    run_phase(0, 64, 80);

    // Shadows off, both sides idling
    drain_results();
    write_reg(REG_SHADOW_ENABLE, 16'd0);
    write_reg(REG_ELEV_MIN, 16'sh8000);
    write_reg(REG_ELEV_MAX, 16'sh7fff);
    run_phase(21, 21, 70);

    // Shadows back on in the middle of a row
    drain_results();
    write_reg(REG_SHADOW_ENABLE, 16'd1);
    run_phase(0, 0, 60);

    // Clamp pinned to the top, then to the bottom
    drain_results();
    write_reg(REG_ELEV_MIN, 16'sh7fff);
    write_reg(REG_ELEV_MAX, 16'sh7fff);
    run_phase(64, 0, 40);

    drain_results();
    write_reg(REG_ELEV_MIN, 16'sh8000);
    write_reg(REG_ELEV_MAX, 16'sh8000);
    run_phase(0, 64, 40);

    // Moderate range, both sides idling
    drain_results();
    write_reg(REG_ELEV_MIN, -16'sd1000);
    write_reg(REG_ELEV_MAX, 16'sd1000);
    run_phase(21, 21, 90);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d cells in %0d random rows (%0d past the march window), %0d shadowed",
             cells_sent, rows_sent, long_rows, shadow_seen);
    $display("%0d register writes: full, narrow, inverted and pinned clamps, shadows off and on",
             cfg_writes);
    if (err_cnt == 0 && pending_shadow_q.size() == 0) begin
      $display("heightfield_shadow_mask_tb OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", err_cnt, pending_shadow_q.size());
      $display("heightfield_shadow_mask_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hsm_pkg.sv
rtl/hsm_in_if.sv
rtl/hsm_out_if.sv
rtl/hsm_cfg_if.sv
rtl/hsm_cell.sv
rtl/hsm_or_stage.sv
rtl/heightfield_shadow_mask.sv
test/heightfield_shadow_mask_tb.sv
